@@ design/sttk_pkg.sv @@
// ============================================================================
// sttk_pkg: shared types and constants of the source text tokenizer
// Token kinds, scanner modes, token and queue entry records, character codes
// and the small classification helpers used by the front end.
// ============================================================================
package sttk_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [3:0] {
    KIND_ASSIGN    = 4'd0,
    KIND_PLUS      = 4'd1,
    KIND_LPAREN    = 4'd2,
    KIND_RPAREN    = 4'd3,
    KIND_LBRACE    = 4'd4,
    KIND_RBRACE    = 4'd5,
    KIND_COMMA     = 4'd6,
    KIND_SEMICOLON = 4'd7,
    KIND_STRING    = 4'd8,
    KIND_EOF       = 4'd9,
    KIND_IDENT     = 4'd10,
    KIND_INT       = 4'd11,
    KIND_ILLEGAL   = 4'd12
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_INT    = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t                  kind;
    logic [COUNT_BITS-1:0]  line;
    logic [COUNT_BITS-1:0]  column;
    logic [OFFSET_BITS-1:0] offset;
    logic [COUNT_BITS-1:0]  length;
    logic [7:0]             tbyte;
  } token_t;

  // One queue entry holds every token caused by one text byte.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], CH_UNDER});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {[CH_D0:CH_D9]});
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b inside {CH_EQ, CH_PLUS, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC,
                      CH_COMMA, CH_SEMI});
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_EQ:    k = KIND_ASSIGN;
      CH_PLUS:  k = KIND_PLUS;
      CH_LPAR:  k = KIND_LPAREN;
      CH_RPAR:  k = KIND_RPAREN;
      CH_LBRC:  k = KIND_LBRACE;
      CH_RBRC:  k = KIND_RBRACE;
      CH_COMMA: k = KIND_COMMA;
      CH_SEMI:  k = KIND_SEMICOLON;
      default:  k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

endpackage

@@ design/sttk_queue.sv @@
// ============================================================================
// sttk_queue: short token queue between scanner and emitter
// Register-based FIFO of queue entries with a fill count and a
// combinational view of the head entry.
// ============================================================================
module sttk_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sttk_pkg::entry_t push_entry,
  input  logic            pop,
  output sttk_pkg::entry_t head_entry,
  output sttk_pkg::qstat_t status
);
  import sttk_pkg::*;

  entry_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry   = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));

endmodule

@@ design/sttk_front.sv @@
// ============================================================================
// sttk_front: byte scanner
// Tracks position and scan mode, classifies each accepted byte and pushes
// the tokens it causes into the queue as one entry.
// ============================================================================
module sttk_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  output logic             push,
  output sttk_pkg::entry_t push_entry
);
  import sttk_pkg::*;

  mode_t                  mode_r, mode_nxt;
  logic [COUNT_BITS-1:0]  line_r, line_nxt;
  logic [COUNT_BITS-1:0]  col_r, col_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [COUNT_BITS-1:0]  oline_r, oline_nxt;
  logic [COUNT_BITS-1:0]  ocol_r, ocol_nxt;
  logic [OFFSET_BITS-1:0] ooff_r, ooff_nxt;
  logic [COUNT_BITS-1:0]  olen_r, olen_nxt;

  logic                   nl, is_end, is_quote, more, scan, have_a, have_b;
  logic [COUNT_BITS-1:0]  line_adv, col_adv;
  token_t                 tok_a, tok_b;

  always_comb begin
    nl       = (text_byte == CH_LF);
    is_end   = (text_byte == CH_END);
    is_quote = (text_byte == CH_QUOTE);
    line_adv = nl ? sat_cnt(line_r) : line_r;
    col_adv  = nl ? '0 : sat_cnt(col_r);
    more     = 1'b0;
    scan     = 1'b0;
    have_a   = 1'b0;
    have_b   = 1'b0;

    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    off_nxt   = off_r;
    oline_nxt = oline_r;
    ocol_nxt  = ocol_r;
    ooff_nxt  = ooff_r;
    olen_nxt  = olen_r;

    // Token A closes the open token; its kind is set below.
    tok_a.kind   = KIND_STRING;
    tok_a.line   = oline_r;
    tok_a.column = ocol_r;
    tok_a.offset = ooff_r;
    tok_a.length = olen_r;
    tok_a.tbyte  = '0;

    // Token B is whatever the byte itself produces between tokens.
    tok_b.kind   = punct_kind(text_byte);
    tok_b.line   = line_adv;
    tok_b.column = col_adv;
    tok_b.offset = off_r;
    tok_b.length = COUNT_BITS'(1);
    tok_b.tbyte  = text_byte;

    if (accept) begin
      line_nxt = line_adv;
      col_nxt  = col_adv;
      off_nxt  = sat_off(off_r);

      case (mode_r)
        MODE_STRING: begin
          if (is_quote || is_end) begin
            have_a   = 1'b1;
            mode_nxt = MODE_IDLE;
            scan     = is_end;
          end else begin
            olen_nxt = sat_cnt(olen_r);
          end
        end
        MODE_IDENT, MODE_INT: begin
          more = (mode_r == MODE_IDENT) ? (is_letter(text_byte) || is_digit(text_byte))
                                        : is_digit(text_byte);
          if (more) begin
            olen_nxt = sat_cnt(olen_r);
          end else begin
            have_a     = 1'b1;
            tok_a.kind = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_INT;
            mode_nxt   = MODE_IDLE;
            scan       = 1'b1;
          end
        end
        MODE_IDLE: begin
          scan = 1'b1;
        end
        default: begin
          scan = 1'b1;
        end
      endcase

      if (scan) begin
        if (is_blank(text_byte)) begin
          have_b = 1'b0;
        end else if (is_punct(text_byte)) begin
          have_b = 1'b1;
        end else if (is_quote) begin
          mode_nxt  = MODE_STRING;
          oline_nxt = line_adv;
          ocol_nxt  = col_adv;
          ooff_nxt  = sat_off(off_r);
          olen_nxt  = '0;
        end else if (is_end) begin
          // End of text: emit eof and start over as after reset.
          have_b       = 1'b1;
          tok_b.kind   = KIND_EOF;
          tok_b.length = '0;
          tok_b.tbyte  = '0;
          mode_nxt     = MODE_IDLE;
          line_nxt     = COUNT_BITS'(1);
          col_nxt      = '0;
          off_nxt      = '0;
          olen_nxt     = '0;
        end else if (is_letter(text_byte) || is_digit(text_byte)) begin
          mode_nxt  = is_letter(text_byte) ? MODE_IDENT : MODE_INT;
          oline_nxt = line_adv;
          ocol_nxt  = col_adv;
          ooff_nxt  = off_r;
          olen_nxt  = COUNT_BITS'(1);
        end else begin
          have_b     = 1'b1;
          tok_b.kind = KIND_ILLEGAL;
        end
      end
    end

    push            = have_a || have_b;
    push_entry.two  = have_a && have_b;
    push_entry.tok0 = have_a ? tok_a : tok_b;
    push_entry.tok1 = tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= COUNT_BITS'(1);
      col_r  <= '0;
      off_r  <= '0;
      olen_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      off_r  <= off_nxt;
      olen_r <= olen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oline_r <= oline_nxt;
    ocol_r  <= ocol_nxt;
    ooff_r  <= ooff_nxt;
  end

endmodule

@@ design/sttk_back.sv @@
// ============================================================================
// sttk_back: token emitter
// Takes queue entries and presents their tokens one per request on the
// output register, marking the final token of each entry.
// ============================================================================
module sttk_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sttk_pkg::entry_t head_entry,
  input  sttk_pkg::qstat_t qstat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output sttk_pkg::token_t out_tok,
  output logic             out_last
);
  import sttk_pkg::*;

  logic   valid_r, valid_nxt;
  logic   second_r, second_nxt;
  logic   last_r, last_nxt;
  token_t tok_r, tok_nxt;
  logic   load;

  always_comb begin
    load       = !qstat.empty && (!valid_r || !out_stall);
    valid_nxt  = valid_r && out_stall;
    second_nxt = second_r;
    tok_nxt    = tok_r;
    last_nxt   = last_r;
    pop        = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (head_entry.two && !second_r) begin
        tok_nxt    = head_entry.tok0;
        last_nxt   = 1'b0;
        second_nxt = 1'b1;
      end else begin
        tok_nxt    = second_r ? head_entry.tok1 : head_entry.tok0;
        last_nxt   = 1'b1;
        second_nxt = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

@@ design/source_text_tokenizer_top.sv @@
// ============================================================================
// source_text_tokenizer_top: streaming lexical analyzer
// Turns a byte stream of source text into a stream of position-tagged tokens.
// ============================================================================
// Usage. Source text enters one byte per request on the in_ channel; a zero
// byte ends the text, yields the eof token and returns the scanner to its
// start position (line 1, column 0, offset 0), ready for the next text.
// Tokens leave on the out_ channel, one per request, with kind, start line
// and column, literal offset and length, the byte itself for punctuators and
// illegal bytes, and out_last set on the final token caused by a given byte.
// A byte causes zero, one or two tokens; two when it closes an identifier,
// integer or string and is itself a token.
//
// Throughput is one text byte per cycle while in_stall is low. The scanner
// retires a byte in the cycle it is accepted; the emitter delivers one token
// per cycle while out_stall is low and tokens wait. When the queue is empty,
// the first token of a byte passes the queue and the output register before
// it is presented on out_. A four-entry queue between scanner and emitter
// absorbs bytes that cause two tokens and output stalls; in_stall rises only
// when that queue is full. While out_stall is high the presented token holds.
// Reset is synchronous and active low and empties the queue and output.
// ============================================================================
module source_text_tokenizer_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sttk_pkg::kind_t       out_token_kind,
  output logic [15:0]           out_start_line,
  output logic [15:0]           out_start_column,
  output logic [23:0]           out_literal_offset,
  output logic [15:0]           out_literal_length,
  output logic [7:0]            out_token_byte,
  output logic                  out_last
);
  import sttk_pkg::*;

  logic   in_accept;
  logic   q_push, q_pop;
  entry_t q_push_entry, q_head;
  qstat_t q_stat;
  token_t out_tok;

  // The scanner may take a byte whenever the queue has room for its entry.
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  sttk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .text_byte  (in_text_byte),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  sttk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head_entry (q_head),
    .status     (q_stat)
  );

  sttk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (q_head),
    .qstat      (q_stat),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tok    (out_tok),
    .out_last   (out_last)
  );

  // Field widths of the token record match the output ports one for one.
  assign out_token_kind     = out_tok.kind;
  assign out_start_line     = out_tok.line;
  assign out_start_column   = out_tok.column;
  assign out_literal_offset = out_tok.offset;
  assign out_literal_length = out_tok.length;
  assign out_token_byte     = out_tok.tbyte;

  // The queue is never written while it is full.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("token queue written while full");

  // Only a closed identifier, integer or string can precede a second token.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_token_kind == KIND_STRING ||
                                  out_token_kind == KIND_IDENT ||
                                  out_token_kind == KIND_INT))
    else $error("unexpected kind on a non-final token");

  // The second token of a byte follows its first without a gap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("second token of a byte not presented at once");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for source_text_tokenizer_top
// Feeds short source texts byte by byte: a hand-written opening and random
// statements with random gaps on both sides. A scanner model in the bench
// predicts every token, and each delivered token is compared field by field
// with the oldest prediction.
// ============================================================================
module tb;
  import sttk_pkg::*;

  localparam logic [COUNT_BITS-1:0]  CNT_TOP    = {COUNT_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OFF_TOP    = {OFFSET_BITS{1'b1}};
  localparam int                     RAND_BYTES = 750;
  localparam int                     HOLD_AFTER = 150;   // tokens before the long hold
  localparam int                     HOLD_LEN   = 150;   // cycles of the long hold
  localparam int                     QUIET_MAX  = 2000;  // cycles with no request moved
  localparam int                     TAIL       = 20;
  localparam int                     REPORT_MAX = 40;

  // A predicted token and the flag that marks the final token of its byte.
  typedef struct packed {
    token_t tok;
    logic   last;
  } lexeme_t;

  // A queued text byte; rushed bytes are sent with no gap in front.
  typedef struct packed {
    logic [7:0] value;
    logic       rush;
  } text_req_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_text_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  kind_t                  out_token_kind;
  logic [15:0]            out_start_line;
  logic [15:0]            out_start_column;
  logic [23:0]            out_literal_offset;
  logic [15:0]            out_literal_length;
  logic [7:0]             out_token_byte;
  logic                   out_last;

  source_text_tokenizer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_start_line     (out_start_line),
    .out_start_column   (out_start_column),
    .out_literal_offset (out_literal_offset),
    .out_literal_length (out_literal_length),
    .out_token_byte     (out_token_byte),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Text still to be sent, and tokens predicted but not yet delivered.
  text_req_t pending_bytes[$];
  lexeme_t   expected_tokens[$];

  int mismatch_count = 0;
  int tokens_seen    = 0;

  // Handshake bookkeeping. The taken flags are set at the rising edge where a
  // request moves and consumed at the next falling edge by the driving side.
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  int send_wait = -1;
  int send_burst = 0;
  int recv_wait = 0;
  int recv_burst = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  // Scanner state of the bench's own model: current mode, running position,
  // and the start and length of the token that is still open.
  mode_t                  cur_mode;
  logic [COUNT_BITS-1:0]  line_at;
  logic [COUNT_BITS-1:0]  col_at;
  logic [OFFSET_BITS-1:0] text_off;
  logic [COUNT_BITS-1:0]  tok_line;
  logic [COUNT_BITS-1:0]  tok_col;
  logic [OFFSET_BITS-1:0] tok_off;
  logic [COUNT_BITS-1:0]  tok_len;

  function automatic logic [COUNT_BITS-1:0] step_count(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] step_offset(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_TOP) ? v : v + 1'b1;
  endfunction

  function automatic bit word_start(input logic [7:0] b);
    return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) ||
           (b == CH_UNDER);
  endfunction

  function automatic bit digit_char(input logic [7:0] b);
    return b >= CH_D0 && b <= CH_D9;
  endfunction

  function automatic bit blank_char(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic bit punct_char(input logic [7:0] b);
    return b == CH_EQ || b == CH_PLUS || b == CH_LPAR || b == CH_RPAR ||
           b == CH_LBRC || b == CH_RBRC || b == CH_COMMA || b == CH_SEMI;
  endfunction

  function automatic lexeme_t token_of(input kind_t k, input logic [COUNT_BITS-1:0] ln,
                                       input logic [COUNT_BITS-1:0] col,
                                       input logic [OFFSET_BITS-1:0] off,
                                       input logic [COUNT_BITS-1:0] len,
                                       input logic [7:0] tb_byte);
    lexeme_t t;
    t.tok.kind   = k;
    t.tok.line   = ln;
    t.tok.column = col;
    t.tok.offset = off;
    t.tok.length = len;
    t.tok.tbyte  = tb_byte;
    t.last       = 1'b0;
    return t;
  endfunction

  // Back to the start of a text: line 1, column 0, offset 0, nothing open.
  task automatic restart_scan();
    cur_mode = MODE_IDLE;
    line_at  = COUNT_BITS'(1);
    col_at   = '0;
    text_off = '0;
    tok_line = '0;
    tok_col  = '0;
    tok_off  = '0;
    tok_len  = '0;
  endtask

  // Scans one accepted byte and queues the tokens it closes, at most two.
  task automatic lex_byte(input logic [7:0] b);
    lexeme_t                found [2];
    int                     n;
    bit                     scanned;
    kind_t                  pk;
    logic [COUNT_BITS-1:0]  ln;
    logic [COUNT_BITS-1:0]  col;
    logic [OFFSET_BITS-1:0] off;
    n = 0;
    scanned = 1'b0;
    // Every byte moves the position first; the token sees the moved position.
    if (b == CH_LF) begin
      line_at = step_count(line_at);
      col_at  = '0;
    end else begin
      col_at = step_count(col_at);
    end
    ln  = line_at;
    col = col_at;
    off = text_off;
    text_off = step_offset(text_off);
    case (cur_mode)
      MODE_STRING: begin
        // A closing quote is swallowed; the end byte closes the string and
        // still yields its own eof token below.
        if (b == CH_QUOTE || b == CH_END) begin
          found[n] = token_of(KIND_STRING, tok_line, tok_col, tok_off, tok_len, 8'h00);
          n = n + 1;
          cur_mode = MODE_IDLE;
          scanned = (b == CH_QUOTE);
        end else begin
          tok_len = step_count(tok_len);
          scanned = 1'b1;
        end
      end
      MODE_IDENT, MODE_INT: begin
        if (digit_char(b) || (cur_mode == MODE_IDENT && word_start(b))) begin
          tok_len = step_count(tok_len);
          scanned = 1'b1;
        end else begin
          found[n] = token_of((cur_mode == MODE_IDENT) ? KIND_IDENT : KIND_INT,
                              tok_line, tok_col, tok_off, tok_len, 8'h00);
          n = n + 1;
          cur_mode = MODE_IDLE;
        end
      end
      default: ;
    endcase
    if (!scanned) begin
      if (blank_char(b)) begin
      end else if (punct_char(b)) begin
        case (b)
          CH_EQ:    pk = KIND_ASSIGN;
          CH_PLUS:  pk = KIND_PLUS;
          CH_LPAR:  pk = KIND_LPAREN;
          CH_RPAR:  pk = KIND_RPAREN;
          CH_LBRC:  pk = KIND_LBRACE;
          CH_RBRC:  pk = KIND_RBRACE;
          CH_COMMA: pk = KIND_COMMA;
          default:  pk = KIND_SEMICOLON;
        endcase
        found[n] = token_of(pk, ln, col, off, COUNT_BITS'(1), b);
        n = n + 1;
      end else if (b == CH_QUOTE) begin
        // The literal starts one past the quote; the position is the quote's.
        cur_mode = MODE_STRING;
        tok_line = ln;
        tok_col  = col;
        tok_off  = step_offset(off);
        tok_len  = '0;
      end else if (b == CH_END) begin
        found[n] = token_of(KIND_EOF, ln, col, off, '0, 8'h00);
        n = n + 1;
        restart_scan();
      end else if (word_start(b) || digit_char(b)) begin
        cur_mode = word_start(b) ? MODE_IDENT : MODE_INT;
        tok_line = ln;
        tok_col  = col;
        tok_off  = off;
        tok_len  = COUNT_BITS'(1);
      end else begin
        found[n] = token_of(KIND_ILLEGAL, ln, col, off, COUNT_BITS'(1), b);
        n = n + 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      expected_tokens.push_back(found[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("MISMATCH token %0d: %s got %0h expected %0h", tokens_seen, what, got, want);
  endtask

  task automatic check_token();
    lexeme_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("token with none predicted, kind", 32'(out_token_kind), 32'd0);
      return;
    end
    want = expected_tokens.pop_front();
    if (out_token_kind !== want.tok.kind)
      report_mismatch("token_kind", 32'(out_token_kind), 32'(want.tok.kind));
    if (out_start_line !== want.tok.line)
      report_mismatch("start_line", 32'(out_start_line), 32'(want.tok.line));
    if (out_start_column !== want.tok.column)
      report_mismatch("start_column", 32'(out_start_column), 32'(want.tok.column));
    if (out_literal_offset !== want.tok.offset)
      report_mismatch("literal_offset", 32'(out_literal_offset), 32'(want.tok.offset));
    if (out_literal_length !== want.tok.length)
      report_mismatch("literal_length", 32'(out_literal_length), 32'(want.tok.length));
    if (out_token_byte !== want.tok.tbyte)
      report_mismatch("token_byte", 32'(out_token_byte), 32'(want.tok.tbyte));
    if (out_last !== want.last)
      report_mismatch("last", 32'(out_last), 32'(want.last));
  endtask

  // Gap in front of the next request: mostly drawn at random, with occasional
  // bursts of back-to-back requests.
  function automatic int pick_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic add_byte(input logic [7:0] v, input bit rush);
    text_req_t r;
    r.value = v;
    r.rush  = rush;
    pending_bytes.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  // Random letter, or letter or digit when digits are allowed.
  function automatic logic [7:0] rand_word_char(input bit allow_digit);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (!(word_start(v) || (allow_digit && digit_char(v))));
    return v;
  endfunction

  // Input driver. A new byte is offered only once the previous one has been
  // taken; while it waits it holds steady. During the long output hold the
  // sender drops its gaps so that the internal queue fills and in_stall rises.
  always @(negedge clk) begin
    text_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (send_wait < 0 && pending_bytes.size() != 0)
        send_wait = pending_bytes[0].rush ? 0 : pick_wait(send_burst);
      if (send_wait > 0 && hold_left == 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        req = pending_bytes.pop_front();
        in_valid     <= 1'b1;
        in_text_byte <= req.value;
        send_wait = -1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: after each delivered token a fresh stall count is drawn and
  // spent while a token is presented. The long hold overrides the drawn stalls.
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      recv_wait = pick_wait(recv_burst);
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (recv_wait > 0 && out_valid) begin
      recv_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor. Runs the model on every accepted byte before checking the token
  // delivered in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        lex_byte(in_text_byte);
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        check_token();
        tokens_seen++;
        out_taken = 1'b1;
      end
    end
  end

  // Long output hold: once enough tokens have passed, the receiver holds off
  // while the sender keeps offering bytes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && tokens_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
    end
  end

  // Watchdog: too long without any request moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no request moved for %0d cycles", QUIET_MAX);
        $display("source_text_tokenizer_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int         rand_start;
    int         pick;
    int         count;
    logic [7:0] v;
    restart_scan();

    // Opening text: an identifier with digit and underscore closed by a
    // brace, every punctuator, an integer closed by a letter, the blanks
    // other than space, illegal bytes at both ends of the range, a string
    // with a high byte, and a string that the end of text closes.
    add_text("Zz_9{=+(7a),};");
    add_byte(CH_TAB, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_text("\"");
    add_byte(8'h80, 1'b0);
    add_text("\"\"k");
    add_byte(CH_END, 1'b0);

    // Random statements: mostly well-formed pieces glued together, so that
    // tokens are often closed by the next token, plus illegal, end and raw bytes.
    rand_start = pending_bytes.size();
    while (pending_bytes.size() - rand_start < RAND_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        add_byte(rand_word_char(1'b0), 1'b0);
        count = $urandom_range(0, 6);
        for (int i = 0; i < count; i++) add_byte(rand_word_char(1'b1), 1'b0);
      end else if (pick < 8) begin
        count = $urandom_range(1, 5);
        for (int i = 0; i < count; i++) add_byte(8'($urandom_range(CH_D0, CH_D9)), 1'b0);
        if ($urandom_range(0, 2) == 0) add_byte(rand_word_char(1'b0), 1'b0);
      end else if (pick < 11) begin
        do v = 8'($urandom_range(0, 255));
        while (!punct_char(v));
        add_byte(v, 1'b0);
      end else if (pick < 13) begin
        add_byte(CH_QUOTE, 1'b0);
        count = $urandom_range(0, 8);
        for (int i = 0; i < count; i++) begin
          do v = 8'($urandom_range(1, 255));
          while (v == CH_QUOTE);
          add_byte(v, 1'b0);
        end
        add_byte(($urandom_range(0, 5) == 0) ? CH_END : CH_QUOTE, 1'b0);
      end else if (pick < 16) begin
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++) begin
          do v = 8'($urandom_range(0, 255));
          while (!blank_char(v));
          add_byte(v, 1'b0);
        end
      end else if (pick < 17) begin
        do v = 8'($urandom_range(0, 255));
        while (word_start(v) || digit_char(v) || blank_char(v) || punct_char(v) ||
               v == CH_QUOTE || v == CH_END);
        add_byte(v, 1'b0);
      end else if (pick < 18) begin
        add_byte(CH_END, 1'b0);
      end else begin
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    add_byte(CH_END, 1'b0);

    // Reset is held from the start and released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every byte is taken and every predicted token delivered;
    // the short delay keeps the test clear of the edge-time updates.
    do begin
      @(posedge clk);
      #1;
    end while (pending_bytes.size() != 0 || in_valid || expected_tokens.size() != 0);
    repeat (TAIL) @(posedge clk);
    #1;
    if (expected_tokens.size() != 0)
      report_mismatch("tokens never delivered", 32'd0, expected_tokens.size());

    if (mismatch_count == 0) begin
      $display("source_text_tokenizer_top verification clean");
    end else begin
      $display("source_text_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sttk_pkg.sv
design/sttk_queue.sv
design/sttk_front.sv
design/sttk_back.sv
design/source_text_tokenizer_top.sv
tb/sv/tb.sv
